// ===== design/mric_pkg.sv =====
// shared constants, types and state codes for the rotation inversion block
package mric_pkg;

  localparam int MaxLength = 16;
  localparam int ElemW     = 4;
  localparam int OutW      = 7;
  localparam int CfgW      = 5;
  localparam int IdxW      = $clog2(MaxLength);
  localparam int LenW      = $clog2(MaxLength + 1);
  localparam int InvRawW   = $clog2(MaxLength * MaxLength) + 2;
  localparam int InvW      = (InvRawW > OutW + 1) ? InvRawW : OutW + 1;
  localparam int OutMax    = (1 << OutW) - 1;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int ApbAddrW = 2;
  localparam int ApbDataW = 32;

  localparam logic [ApbAddrW-1:0] RegAddrSeqLength = ApbAddrW'(0);
  localparam logic [CfgW-1:0]     SeqLengthReset   = CfgW'(16);

  typedef struct packed {
    logic [ElemW-1:0] elem;
    logic [IdxW-1:0]  pos;
    logic             last;
    logic             rebuild;
  } item_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
    logic             empty;
  } q_status_t;

  typedef enum logic [6:0] {
    BkIdle   = 7'b0000001,
    BkLoad   = 7'b0000010,
    BkRbLoad = 7'b0000100,
    BkRbScan = 7'b0001000,
    BkRtLoad = 7'b0010000,
    BkRtScan = 7'b0100000,
    BkRtUpd  = 7'b1000000
  } back_state_e;

endpackage

// ===== design/min_rotation_inversion_count.sv =====
// top level: config register, front/back with element queue, result register
// each element is compared in the back end against the elements stored before
// it; the last element of a sequence then starts the rotation sweep, preceded
// by a recount when n shrank, and the result is emitted after the sweep; the
// back end takes a new element only while idle and reads the element store
// through a single read port; reset clears the state, pointer and valid registers
module min_rotation_inversion_count (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [mric_pkg::ElemW-1:0]      element_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [mric_pkg::OutW-1:0]       min_inversions_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mric_pkg::ApbAddrW-1:0]   paddr,
  input  logic [mric_pkg::ApbDataW-1:0]   pwdata,
  output logic [mric_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  logic [mric_pkg::CfgW-1:0]  seq_length_q, seq_length_d;
  logic [mric_pkg::LenW-1:0]  seq_len;
  logic                       cfg_we;

  mric_pkg::item_t            fq_item, qb_item;
  mric_pkg::q_status_t        q_status;
  logic                       fq_wr, qb_rd;

  logic                       out_valid_q, out_valid_d;
  logic [mric_pkg::OutW-1:0]  out_data_q, out_data_d;
  logic                       res_we, res_ready;
  logic [mric_pkg::OutW-1:0]  res_value;
  logic                       pop_ok;

  // configuration transaction
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == mric_pkg::RegAddrSeqLength);
  assign seq_length_d = cfg_we ? pwdata[mric_pkg::CfgW-1:0] : seq_length_q;
  assign prdata = (paddr == mric_pkg::RegAddrSeqLength) ?
                  mric_pkg::ApbDataW'(seq_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_length_q <= mric_pkg::SeqLengthReset;
    end else begin
      seq_length_q <= seq_length_d;
    end
  end

  always_comb begin
    if (seq_length_q < mric_pkg::CfgW'(2)) begin
      seq_len = mric_pkg::LenW'(2);
    end else if (int'(seq_length_q) > mric_pkg::MaxLength) begin
      seq_len = mric_pkg::LenW'(mric_pkg::MaxLength);
    end else begin
      seq_len = mric_pkg::LenW'(seq_length_q);
    end
  end

  assign full = q_status.full;

  mric_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .element_i  (element_i),
    .seq_len_i  (seq_len),
    .q_status_i (q_status),
    .q_wr_o     (fq_wr),
    .q_item_o   (fq_item)
  );

  mric_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fq_wr),
    .wr_item_i (fq_item),
    .rd_i      (qb_rd),
    .rd_item_o (qb_item),
    .status_o  (q_status)
  );

  mric_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seq_len_i   (seq_len),
    .q_item_i    (qb_item),
    .q_empty_i   (q_status.empty),
    .q_rd_o      (qb_rd),
    .res_ready_i (res_ready),
    .res_we_o    (res_we),
    .res_value_o (res_value)
  );

  // result register
  assign empty     = !out_valid_q;
  assign pop_ok    = pop && out_valid_q;
  assign res_ready = !out_valid_q || pop_ok;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pop_ok) begin
      out_valid_d = 1'b0;
    end
    if (res_we) begin
      out_valid_d = 1'b1;
      out_data_d  = res_value;
    end
  end

  assign min_inversions_o = out_data_q;

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we |-> (!out_valid_q || pop_ok))
    else $error("result written while an unread result is pending");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we |=> (out_valid_q && min_inversions_o == $past(res_value)))
    else $error("result write did not reach the output register");

  a_queue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fq_wr && !qb_rd) |=> (q_status.count == $past(q_status.count) + mric_pkg::QCntW'(1)))
    else $error("queue count did not track an accepted element");

endmodule

// ===== design/mric_front.sv =====
// front end: accepts elements, tags each with its slot and end-of-sequence flags
module mric_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [mric_pkg::ElemW-1:0]    element_i,
  input  logic [mric_pkg::LenW-1:0]     seq_len_i,
  input  mric_pkg::q_status_t           q_status_i,
  output logic                          q_wr_o,
  output mric_pkg::item_t               q_item_o
);

  logic [mric_pkg::LenW-1:0] cnt_q, cnt_d;
  logic [mric_pkg::LenW-1:0] pos_full;
  logic [mric_pkg::LenW-1:0] pos_next;
  logic                      accept;

  assign accept = push_i && !q_status_i.full;

  // past the last slot, elements keep landing on the last slot
  always_comb begin
    if (cnt_q >= mric_pkg::LenW'(mric_pkg::MaxLength - 1)) begin
      pos_full = mric_pkg::LenW'(mric_pkg::MaxLength - 1);
    end else begin
      pos_full = cnt_q;
    end
    pos_next = pos_full + mric_pkg::LenW'(1);
  end

  assign q_wr_o           = accept;
  assign q_item_o.elem    = element_i;
  assign q_item_o.pos     = pos_full[mric_pkg::IdxW-1:0];
  assign q_item_o.last    = (pos_next >= seq_len_i);
  assign q_item_o.rebuild = (pos_next != seq_len_i);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = q_item_o.last ? '0 : pos_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/mric_queue.sv =====
// small fifo of tagged elements between front and back
module mric_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  mric_pkg::item_t     wr_item_i,
  input  logic                rd_i,
  output mric_pkg::item_t     rd_item_o,
  output mric_pkg::q_status_t status_o
);

  mric_pkg::item_t                mem_q [mric_pkg::QDepth];
  logic [mric_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [mric_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [mric_pkg::QCntW-1:0]     count_q, count_d;
  logic                           do_wr, do_rd;

  assign status_o.count = count_q;
  assign status_o.full  = (count_q == mric_pkg::QCntW'(mric_pkg::QDepth));
  assign status_o.empty = (count_q == '0);

  assign do_wr = wr_i && !status_o.full;
  assign do_rd = rd_i && !status_o.empty;

  assign rd_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + mric_pkg::QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + mric_pkg::QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + mric_pkg::QCntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - mric_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== design/mric_back.sv =====
// back end: element store, running inversion count and rotation sweep
module mric_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mric_pkg::LenW-1:0]     seq_len_i,
  input  mric_pkg::item_t               q_item_i,
  input  logic                          q_empty_i,
  output logic                          q_rd_o,
  input  logic                          res_ready_i,
  output logic                          res_we_o,
  output logic [mric_pkg::OutW-1:0]     res_value_o
);

  mric_pkg::back_state_e state_q, state_d;

  logic [mric_pkg::ElemW-1:0]       store_q [mric_pkg::MaxLength];
  logic [mric_pkg::ElemW-1:0]       v_q, v_d;
  logic [mric_pkg::ElemW-1:0]       x_q, x_d;
  logic [mric_pkg::IdxW-1:0]        pos_q, pos_d;
  logic                             last_q, last_d;
  logic                             rebuild_q, rebuild_d;
  logic [mric_pkg::IdxW-1:0]        j_q, j_d;
  logic [mric_pkg::IdxW-1:0]        ir_q, ir_d;
  logic [mric_pkg::LenW-1:0]        k_q, k_d;
  logic signed [mric_pkg::InvW-1:0] inv_q, inv_d;
  logic signed [mric_pkg::InvW-1:0] best_q, best_d;
  logic                             done_q, done_d;

  logic [mric_pkg::IdxW-1:0]        rd_idx;
  logic [mric_pkg::ElemW-1:0]       rd_data;
  logic [mric_pkg::IdxW-1:0]        last_idx, last_rot;
  logic signed [mric_pkg::InvW-1:0] inv_inc, inv_rot;
  logic                             hit;
  logic                             store_we;

  assign last_idx = mric_pkg::IdxW'(seq_len_i - mric_pkg::LenW'(1));
  assign last_rot = mric_pkg::IdxW'(seq_len_i - mric_pkg::LenW'(2));

  // single read port on the store
  assign rd_idx  = (state_q == mric_pkg::BkRbLoad || state_q == mric_pkg::BkRtLoad) ? ir_q : j_q;
  assign rd_data = store_q[rd_idx];

  assign hit     = (state_q == mric_pkg::BkLoad) ? (rd_data > v_q) : (rd_data < x_q);
  assign inv_inc = inv_q + (hit ? mric_pkg::InvW'(1) : mric_pkg::InvW'(0));
  // front element moves to the back: count changes by (n-1) - 2k
  assign inv_rot = inv_q + mric_pkg::InvW'(seq_len_i) - mric_pkg::InvW'(1)
                 - mric_pkg::InvW'({k_q, 1'b0});

  assign q_rd_o   = (state_q == mric_pkg::BkIdle) && !done_q && !q_empty_i;
  assign store_we = q_rd_o;
  assign res_we_o = (state_q == mric_pkg::BkIdle) && done_q && res_ready_i;

  always_comb begin
    if (best_q < 0) begin
      res_value_o = '0;
    end else if (best_q > mric_pkg::InvW'(mric_pkg::OutMax)) begin
      res_value_o = mric_pkg::OutW'(mric_pkg::OutMax);
    end else begin
      res_value_o = best_q[mric_pkg::OutW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    v_d       = v_q;
    x_d       = x_q;
    pos_d     = pos_q;
    last_d    = last_q;
    rebuild_d = rebuild_q;
    j_d       = j_q;
    ir_d      = ir_q;
    k_d       = k_q;
    inv_d     = inv_q;
    best_d    = best_q;
    done_d    = done_q;
    unique case (state_q)
      mric_pkg::BkIdle: begin
        if (done_q) begin
          if (res_ready_i) begin
            done_d = 1'b0;
            inv_d  = '0;
          end
        end else if (!q_empty_i) begin
          v_d       = q_item_i.elem;
          pos_d     = q_item_i.pos;
          last_d    = q_item_i.last;
          rebuild_d = q_item_i.rebuild;
          j_d       = '0;
          // the first element has nothing before it
          if (q_item_i.pos != '0) begin
            state_d = mric_pkg::BkLoad;
          end
        end
      end
      mric_pkg::BkLoad: begin
        inv_d = inv_inc;
        if (j_q == pos_q - mric_pkg::IdxW'(1)) begin
          ir_d = '0;
          if (!last_q) begin
            state_d = mric_pkg::BkIdle;
          end else if (rebuild_q) begin
            inv_d   = '0;
            state_d = mric_pkg::BkRbLoad;
          end else begin
            best_d  = inv_inc;
            state_d = mric_pkg::BkRtLoad;
          end
        end else begin
          j_d = j_q + mric_pkg::IdxW'(1);
        end
      end
      mric_pkg::BkRbLoad: begin
        x_d     = rd_data;
        j_d     = ir_q + mric_pkg::IdxW'(1);
        state_d = mric_pkg::BkRbScan;
      end
      mric_pkg::BkRbScan: begin
        inv_d = inv_inc;
        if (j_q == last_idx) begin
          if (ir_q == last_rot) begin
            best_d  = inv_inc;
            ir_d    = '0;
            state_d = mric_pkg::BkRtLoad;
          end else begin
            ir_d    = ir_q + mric_pkg::IdxW'(1);
            state_d = mric_pkg::BkRbLoad;
          end
        end else begin
          j_d = j_q + mric_pkg::IdxW'(1);
        end
      end
      mric_pkg::BkRtLoad: begin
        x_d     = rd_data;
        j_d     = '0;
        k_d     = '0;
        state_d = mric_pkg::BkRtScan;
      end
      mric_pkg::BkRtScan: begin
        if (hit) begin
          k_d = k_q + mric_pkg::LenW'(1);
        end
        if (j_q == last_idx) begin
          state_d = mric_pkg::BkRtUpd;
        end else begin
          j_d = j_q + mric_pkg::IdxW'(1);
        end
      end
      mric_pkg::BkRtUpd: begin
        inv_d = inv_rot;
        if (inv_rot < best_q) begin
          best_d = inv_rot;
        end
        if (ir_q == last_rot) begin
          done_d  = 1'b1;
          state_d = mric_pkg::BkIdle;
        end else begin
          ir_d    = ir_q + mric_pkg::IdxW'(1);
          state_d = mric_pkg::BkRtLoad;
        end
      end
      default: begin
        state_d = mric_pkg::BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[q_item_i.pos] <= q_item_i.elem;
    end
    v_q       <= v_d;
    x_q       <= x_d;
    pos_q     <= pos_d;
    last_q    <= last_d;
    rebuild_q <= rebuild_d;
    j_q       <= j_d;
    ir_q      <= ir_d;
    k_q       <= k_d;
    best_q    <= best_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mric_pkg::BkIdle;
      inv_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      inv_q   <= inv_d;
      done_q  <= done_d;
    end
  end

endmodule
